/* hw/rtl/jsu_pkg.sv */
`timescale 1ns / 1ps

package jsu_pkg;

  // Parser phases
  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_STR         = 3'd1;
  localparam logic [2:0] PH_ESC         = 3'd2;
  localparam logic [2:0] PH_HEX1        = 3'd3;
  localparam logic [2:0] PH_AFTER_HI    = 3'd4;
  localparam logic [2:0] PH_AFTER_HI_BS = 3'd5;
  localparam logic [2:0] PH_HEX2        = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Special input bytes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // One queued command: one to four results of the same kind.
  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      last_idx;   // number of results minus one
    logic [3:0][7:0] bytes;
  } cmd_t;

endpackage

/* hw/rtl/json_string_unescape_utf8_core.sv */
`timescale 1ns / 1ps

// Channel   Ports                                  Transfer
// input     push, full, in_byte[7:0]               push && !full
// result    empty, pop, out_byte[7:0],             pop && !empty
//           out_kind[1:0], out_last
//
// One input byte per cycle while the command queue has room; the parser queues
// at most one command per byte. The result stage sends one result per cycle while
// pop is held, so a byte that becomes a four byte UTF-8 sequence gives four results.
// A byte's first result passes through the queue and the result stage register
// before it reaches the ports; full rises with QUEUE_DEPTH commands waiting.
// Reset (rst_n low, synchronous) empties queue and result stage, parser goes idle.

module json_string_unescape_utf8_core #(
  parameter int QUEUE_DEPTH = 4   // commands between parser and result stage, >= 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  // result channel
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last
);

  logic          in_xfer;     // input transfer this cycle
  logic          cmd_valid;
  jsu_pkg::cmd_t cmd;
  logic          q_empty;
  logic          q_pop;
  jsu_pkg::cmd_t q_data;

  assign in_xfer = push && !full;

  // Front: phase tracking, escape and hex decoding, UTF-8 encoding.
  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_xfer),
    .in_byte   (in_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // Queue of decoded commands; full here is what stalls the input side.
  jsu_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_xfer && cmd_valid),
    .wr_data (cmd),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Back: serializes each command into one result per transfer.
  jsu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_kind (out_kind),
    .out_last (out_last)
  );

  // End markers and errors are always single results.
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != jsu_pkg::KIND_DATA) |-> out_last)
    else $error("end/error result without last");

  // A multi-byte sequence never breaks up after a middle transfer.
  a_seq_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last) |=> !empty)
    else $error("result stream broke inside a sequence");

  // End and error markers carry a zero byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == jsu_pkg::KIND_END || out_kind == jsu_pkg::KIND_ERR))
      |-> (out_byte == 8'h00))
    else $error("marker result with nonzero byte");

endmodule

/* hw/rtl/jsu_front.sv */
`timescale 1ns / 1ps

module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,       // input transfer this cycle
  input  logic [7:0]       in_byte,
  output logic             cmd_valid,
  output jsu_pkg::cmd_t    cmd
);

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [9:0]  hi_r, hi_nxt;

  logic        err;
  logic [4:0]  nib;
  logic [15:0] cu;
  logic [20:0] cp_pair;

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_nib(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

  function automatic jsu_pkg::cmd_t utf8_cmd(input logic [20:0] cp);
    jsu_pkg::cmd_t c;
    c       = '0;
    c.kind  = jsu_pkg::KIND_DATA;
    if (cp[20:7] == '0) begin
      c.last_idx = 2'd0;
      c.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp[20:11] == '0) begin
      c.last_idx = 2'd1;
      c.bytes[0] = {3'b110, cp[10:6]};
      c.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp[20:16] == '0) begin
      c.last_idx = 2'd2;
      c.bytes[0] = {4'b1110, cp[15:12]};
      c.bytes[1] = {2'b10, cp[11:6]};
      c.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      c.last_idx = 2'd3;
      c.bytes[0] = {5'b11110, cp[20:18]};
      c.bytes[1] = {2'b10, cp[17:12]};
      c.bytes[2] = {2'b10, cp[11:6]};
      c.bytes[3] = {2'b10, cp[5:0]};
    end
    return c;
  endfunction

  assign nib     = hex_nib(in_byte);
  assign cu      = {accum_r[11:0], nib[3:0]};
  assign cp_pair = 21'h10000 + {1'b0, hi_r, cu[9:0]};

  always_comb begin
    phase_nxt  = phase_r;
    digits_nxt = digits_r;
    accum_nxt  = accum_r;
    hi_nxt     = hi_r;
    err        = 1'b0;
    cmd_valid  = 1'b0;
    cmd        = '0;
    cmd.kind   = jsu_pkg::KIND_DATA;

    unique case (phase_r)
      jsu_pkg::PH_IDLE: begin
        if (in_byte == jsu_pkg::CH_QUOTE) phase_nxt = jsu_pkg::PH_STR;
        else                              err = 1'b1;
      end
      jsu_pkg::PH_STR: begin
        if (in_byte == jsu_pkg::CH_QUOTE) begin
          cmd_valid = 1'b1;
          cmd.kind  = jsu_pkg::KIND_END;
          phase_nxt = jsu_pkg::PH_IDLE;
        end else if (in_byte == jsu_pkg::CH_BSLASH) begin
          phase_nxt = jsu_pkg::PH_ESC;
        end else if (in_byte < jsu_pkg::CH_SPACE) begin
          err = 1'b1;
        end else begin
          cmd_valid    = 1'b1;
          cmd.bytes[0] = in_byte;
        end
      end
      jsu_pkg::PH_ESC: begin
        phase_nxt = jsu_pkg::PH_STR;
        cmd_valid = 1'b1;
        unique case (in_byte)
          8'h22, 8'h5C, 8'h2F: cmd.bytes[0] = in_byte;
          8'h62:               cmd.bytes[0] = 8'h08;  // \b
          8'h66:               cmd.bytes[0] = 8'h0C;  // \f
          8'h6E:               cmd.bytes[0] = 8'h0A;  // \n
          8'h72:               cmd.bytes[0] = 8'h0D;  // \r
          8'h74:               cmd.bytes[0] = 8'h09;  // \t
          8'h75: begin
            cmd_valid  = 1'b0;
            phase_nxt  = jsu_pkg::PH_HEX1;
            digits_nxt = '0;
            accum_nxt  = '0;
          end
          default: err = 1'b1;
        endcase
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
        if (!nib[4]) begin
          err = 1'b1;
        end else if (digits_r != 2'd3) begin
          accum_nxt  = cu;
          digits_nxt = digits_r + 2'd1;
        end else begin
          digits_nxt = '0;
          accum_nxt  = '0;
          if (phase_r == jsu_pkg::PH_HEX1) begin
            if (cu[15:10] == 6'b110110) begin
              hi_nxt    = cu[9:0];
              phase_nxt = jsu_pkg::PH_AFTER_HI;
            end else if (cu[15:10] == 6'b110111) begin
              err = 1'b1;                    // lone low surrogate
            end else begin
              cmd_valid = 1'b1;
              cmd       = utf8_cmd({5'd0, cu});
              phase_nxt = jsu_pkg::PH_STR;
            end
          end else begin
            if (cu[15:10] != 6'b110111) begin
              err = 1'b1;                    // second unit not a low surrogate
            end else begin
              cmd_valid = 1'b1;
              cmd       = utf8_cmd(cp_pair);
              hi_nxt    = '0;
              phase_nxt = jsu_pkg::PH_STR;
            end
          end
        end
      end
      jsu_pkg::PH_AFTER_HI: begin
        if (in_byte == jsu_pkg::CH_BSLASH) phase_nxt = jsu_pkg::PH_AFTER_HI_BS;
        else                               err = 1'b1;
      end
      jsu_pkg::PH_AFTER_HI_BS: begin
        if (in_byte == jsu_pkg::CH_U) begin
          phase_nxt  = jsu_pkg::PH_HEX2;
          digits_nxt = '0;
          accum_nxt  = '0;
        end else begin
          err = 1'b1;
        end
      end
      default: err = 1'b1;
    endcase

    if (err) begin
      cmd_valid  = 1'b1;
      cmd        = '0;
      cmd.kind   = jsu_pkg::KIND_ERR;
      phase_nxt  = jsu_pkg::PH_IDLE;
    end
    if (phase_nxt == jsu_pkg::PH_IDLE) begin
      digits_nxt = '0;
      accum_nxt  = '0;
      hi_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= jsu_pkg::PH_IDLE;
      digits_r <= '0;
      accum_r  <= '0;
      hi_r     <= '0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      digits_r <= digits_nxt;
      accum_r  <= accum_nxt;
      hi_r     <= hi_nxt;
    end
  end

endmodule

/* hw/rtl/jsu_cmd_fifo.sv */
`timescale 1ns / 1ps

module jsu_cmd_fifo #(
  parameter int DEPTH = 4   // at least 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  jsu_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output jsu_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_wr && !do_rd)      count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

endmodule

/* hw/rtl/jsu_back.sv */
`timescale 1ns / 1ps

module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  jsu_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_kind,
  output logic          out_last
);

  jsu_pkg::cmd_t cur_r;
  logic          cur_valid_r;
  logic [1:0]    pos_r;
  logic          done;     // current command fully transferred this cycle

  assign empty    = !cur_valid_r;
  assign out_byte = cur_r.bytes[pos_r];
  assign out_kind = cur_r.kind;
  assign out_last = (pos_r == cur_r.last_idx);

  assign done  = cur_valid_r && pop && out_last;
  assign q_pop = !q_empty && (!cur_valid_r || done);

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      pos_r       <= '0;
    end else if (done) begin
      cur_valid_r <= 1'b0;
      pos_r       <= '0;
    end else if (cur_valid_r && pop) begin
      pos_r <= pos_r + 2'd1;
    end
  end

endmodule

/* sim/json_string_unescape_utf8_core_test.sv */
`timescale 1ns / 1ps

// Testbench for the JSON string unescaper.
// A byte-level model of the parser runs on every input transfer and queues the
// results it predicts; every result transfer is compared against the oldest one.
// Both sides idle at random; a long hold on the result side fills the block up.

module json_string_unescape_utf8_core_test;

  // Escape letters and the one extra byte the simple escapes accept
  localparam logic [7:0] ESC_SLASH = 8'h2F;
  localparam logic [7:0] ESC_B     = 8'h62;
  localparam logic [7:0] ESC_F     = 8'h66;
  localparam logic [7:0] ESC_N     = 8'h6E;
  localparam logic [7:0] ESC_R     = 8'h72;
  localparam logic [7:0] ESC_T     = 8'h74;

  // UTF-16 surrogate ranges
  localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
  localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  localparam int RANDOM_ITEMS = 360;
  localparam int DRAIN_CYCLES = 16;       // a result passes the queue and the result register before it can transfer
  localparam int CYCLE_LIMIT  = 200000;
  localparam int BACKLOG_HOLD = 70;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } result_t;

  // DUT connections; every input starts at a known value
  logic       clk     = 1'b0;
  logic       rst_n   = 1'b0;
  logic       push    = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       pop     = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  // Decoder model state
  logic [2:0]  dec_phase  = jsu_pkg::PH_IDLE;
  logic [1:0]  hex_count  = 2'd0;
  logic [15:0] unit_accum = 16'h0000;
  logic [9:0]  hi_bits    = 10'h000;

  result_t     decoded_results[$];   // results still owed by the block
  result_t     step_results[$];      // results of the byte being modeled

  bit          idle_on = 1'b1;       // random gaps on both sides when set
  int          hold_request = 0;     // long result-side hold, picked up at negedge
  int          hold_left = 0;
  int          pop_wait = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  json_string_unescape_utf8_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_kind (out_kind),
    .out_last (out_last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic int hex_digit_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void add_result(input logic [7:0] data, input logic [1:0] kind);
    result_t r;
    r.data = data;
    r.kind = kind;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  // One code point as one to four UTF-8 bytes
  function automatic void add_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_result(cp[7:0], jsu_pkg::KIND_DATA);
    end else if (cp <= 21'h7FF) begin
      add_result({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA);
      add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
    end else if (cp <= 21'hFFFF) begin
      add_result({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA);
      add_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA);
      add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
    end else begin
      add_result({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA);
      add_result({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA);
      add_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA);
      add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
    end
  endfunction

  // Advance the model by one accepted byte and queue what the block owes for it
  function automatic void unescape_byte(input logic [7:0] b);
    logic        bad;
    int          nib;
    logic [15:0] unit;
    result_t     r;
    bad = 1'b0;
    step_results.delete();
    case (dec_phase)
      jsu_pkg::PH_IDLE: begin
        if (b == jsu_pkg::CH_QUOTE) dec_phase = jsu_pkg::PH_STR;
        else bad = 1'b1;
      end
      jsu_pkg::PH_STR: begin
        if (b == jsu_pkg::CH_QUOTE) begin
          add_result(8'h00, jsu_pkg::KIND_END);
          dec_phase = jsu_pkg::PH_IDLE;
        end else if (b == jsu_pkg::CH_BSLASH) begin
          dec_phase = jsu_pkg::PH_ESC;
        end else if (b < jsu_pkg::CH_SPACE) begin
          bad = 1'b1;
        end else begin
          add_result(b, jsu_pkg::KIND_DATA);
        end
      end
      jsu_pkg::PH_ESC: begin
        dec_phase = jsu_pkg::PH_STR;
        case (b)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, ESC_SLASH:
            add_result(b, jsu_pkg::KIND_DATA);
          ESC_B: add_result(8'h08, jsu_pkg::KIND_DATA);
          ESC_F: add_result(8'h0C, jsu_pkg::KIND_DATA);
          ESC_N: add_result(8'h0A, jsu_pkg::KIND_DATA);
          ESC_R: add_result(8'h0D, jsu_pkg::KIND_DATA);
          ESC_T: add_result(8'h09, jsu_pkg::KIND_DATA);
          jsu_pkg::CH_U: begin
            dec_phase  = jsu_pkg::PH_HEX1;
            hex_count  = 2'd0;
            unit_accum = 16'h0000;
          end
          default: bad = 1'b1;
        endcase
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
        nib = hex_digit_of(b);
        if (nib < 0) begin
          bad = 1'b1;
        end else begin
          unit_accum = {unit_accum[11:0], nib[3:0]};
          if (hex_count != 2'd3) begin
            hex_count = hex_count + 2'd1;
          end else begin
            unit       = unit_accum;
            hex_count  = 2'd0;
            unit_accum = 16'h0000;
            if (dec_phase == jsu_pkg::PH_HEX1) begin
              if (unit >= HI_SURR_FIRST && unit <= HI_SURR_LAST) begin
                hi_bits   = unit[9:0];
                dec_phase = jsu_pkg::PH_AFTER_HI;
              end else if (unit >= LO_SURR_FIRST && unit <= LO_SURR_LAST) begin
                bad = 1'b1;   // low half with no high half before it
              end else begin
                add_code_point({5'd0, unit});
                dec_phase = jsu_pkg::PH_STR;
              end
            end else if (unit < LO_SURR_FIRST || unit > LO_SURR_LAST) begin
              bad = 1'b1;     // second half is not a low surrogate
            end else begin
              add_code_point(SUPP_BASE + {1'b0, hi_bits, unit[9:0]});
              hi_bits   = 10'h000;
              dec_phase = jsu_pkg::PH_STR;
            end
          end
        end
      end
      jsu_pkg::PH_AFTER_HI: begin
        if (b == jsu_pkg::CH_BSLASH) dec_phase = jsu_pkg::PH_AFTER_HI_BS;
        else bad = 1'b1;
      end
      jsu_pkg::PH_AFTER_HI_BS: begin
        if (b == jsu_pkg::CH_U) begin
          dec_phase  = jsu_pkg::PH_HEX2;
          hex_count  = 2'd0;
          unit_accum = 16'h0000;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase

    // Any error replaces whatever was gathered with one error marker
    if (bad) begin
      step_results.delete();
      add_result(8'h00, jsu_pkg::KIND_ERR);
      dec_phase  = jsu_pkg::PH_IDLE;
      hex_count  = 2'd0;
      unit_accum = 16'h0000;
      hi_bits    = 10'h000;
    end
    foreach (step_results[i]) begin
      r = step_results[i];
      r.last = (i == step_results.size() - 1);
      decoded_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: model on input transfers, compare on result transfers.
  // Both sampled at the rising edge, so the order within the step never matters.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("json_string_unescape_utf8_core: mismatch");
      $finish;
    end else begin
      if (rst_n && push && !full) unescape_byte(in_byte);
      if (rst_n && pop && !empty) begin
        if (decoded_results.size() == 0) begin
          $error("unexpected result: out_byte %h out_kind %0d out_last %0d",
                 out_byte, out_kind, out_last);
          mismatch_count++;
        end else begin
          want = decoded_results.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte);
            mismatch_count++;
          end
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, out_last);
            mismatch_count++;
          end
        end
        // stall before taking the next result
        pop_wait = idle_on ? int'($urandom_range(0, 4)) : 0;
      end
    end
  end

  // Result side: drives pop at the falling edge; a long hold wins over the
  // per-transfer stall and is counted down here.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (pop_wait > 0) begin
      pop <= 1'b0;
      pop_wait--;
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // One transfer. push stays high on return so back-to-back bytes need no
  // second edit of push in the same step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 4)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  // Sender stops and waits for the block to hand over everything owed
  task automatic wait_for_results;
    @(negedge clk);
    push <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_hex4(input logic [15:0] unit);
    logic [3:0] nib;
    logic [7:0] ch;
    for (int i = 3; i >= 0; i--) begin
      nib = unit[i*4 +: 4];
      if (nib < 4'd10) ch = "0" + nib;
      else ch = ($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10;
      send_byte(ch);
    end
  endtask

  task automatic send_unicode_escape(input logic [15:0] unit);
    send_byte(jsu_pkg::CH_BSLASH);
    send_byte(jsu_pkg::CH_U);
    send_hex4(unit);
  endtask

  // Plain byte 0x20..0xFF; quote and backslash go out escaped
  task automatic send_plain;
    logic [7:0] b;
    b = 8'($urandom_range(8'h20, 8'hFF));
    if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH) send_byte(jsu_pkg::CH_BSLASH);
    send_byte(b);
  endtask

  task automatic send_simple_escape;
    logic [7:0] letter;
    case ($urandom_range(0, 7))
      0: letter = jsu_pkg::CH_QUOTE;
      1: letter = jsu_pkg::CH_BSLASH;
      2: letter = ESC_SLASH;
      3: letter = ESC_B;
      4: letter = ESC_F;
      5: letter = ESC_N;
      6: letter = ESC_R;
      default: letter = ESC_T;
    endcase
    send_byte(jsu_pkg::CH_BSLASH);
    send_byte(letter);
  endtask

  function automatic bit is_escape_letter(input logic [7:0] b);
    case (b)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, ESC_SLASH, ESC_B, ESC_F, ESC_N, ESC_R,
      ESC_T, jsu_pkg::CH_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // BMP code unit outside the surrogates, spread over the 1/2/3 byte encodings,
  // with the boundaries picked now and then
  function automatic logic [15:0] pick_bmp_unit;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 7))
        0: return 16'h0000;
        1: return 16'h007F;
        2: return 16'h0080;
        3: return 16'h07FF;
        4: return 16'h0800;
        5: return HI_SURR_FIRST - 16'd1;
        6: return LO_SURR_LAST + 16'd1;
        default: return 16'hFFFF;
      endcase
    end
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, HI_SURR_FIRST - 16'd1));
      default: return 16'($urandom_range(LO_SURR_LAST + 16'd1, 16'hFFFF));
    endcase
  endfunction

  task automatic send_surrogate_pair;
    send_unicode_escape(16'($urandom_range(HI_SURR_FIRST, HI_SURR_LAST)));
    send_unicode_escape(16'($urandom_range(LO_SURR_FIRST, LO_SURR_LAST)));
  endtask

  task automatic send_token;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_plain();
      4, 5: send_simple_escape();
      6, 7: send_unicode_escape(pick_bmp_unit());
      default: send_surrogate_pair();
    endcase
  endtask

  // One malformed ending; the block is back in idle afterwards
  task automatic send_flaw;
    logic [7:0]  b;
    logic [15:0] unit;
    case ($urandom_range(0, 8))
      0: send_byte(8'($urandom_range(1, 31)));        // control byte
      1: send_byte(8'h00);                            // input ended early
      2: begin                                        // unknown escape letter
        b = 8'($urandom_range(0, 255));
        while (is_escape_letter(b)) b = 8'($urandom_range(0, 255));
        send_byte(jsu_pkg::CH_BSLASH);
        send_byte(b);
      end
      3, 4: begin                                     // non-hex byte in a \u
        b = 8'($urandom_range(0, 255));
        while (hex_digit_of(b) >= 0) b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) begin
          send_unicode_escape(16'($urandom_range(HI_SURR_FIRST, HI_SURR_LAST)));
        end
        send_byte(jsu_pkg::CH_BSLASH);
        send_byte(jsu_pkg::CH_U);
        repeat ($urandom_range(0, 3)) send_byte("0");
        send_byte(b);
      end
      5: send_unicode_escape(16'($urandom_range(LO_SURR_FIRST, LO_SURR_LAST))); // lone low
      6: begin                                        // high half, then no \u
        send_unicode_escape(16'($urandom_range(HI_SURR_FIRST, HI_SURR_LAST)));
        if ($urandom_range(0, 1)) begin
          b = 8'($urandom_range(0, 255));
          while (b == jsu_pkg::CH_BSLASH) b = 8'($urandom_range(0, 255));
          send_byte(b);
        end else begin
          b = 8'($urandom_range(0, 255));
          while (b == jsu_pkg::CH_U) b = 8'($urandom_range(0, 255));
          send_byte(jsu_pkg::CH_BSLASH);
          send_byte(b);
        end
      end
      default: begin                                  // second half not a low surrogate
        unit = 16'($urandom_range(0, 16'hFFFF));
        while (unit >= LO_SURR_FIRST && unit <= LO_SURR_LAST) begin
          unit = 16'($urandom_range(0, 16'hFFFF));
        end
        send_unicode_escape(16'($urandom_range(HI_SURR_FIRST, HI_SURR_LAST)));
        send_unicode_escape(unit);
      end
    endcase
  endtask

  task automatic send_string(input bit broken);
    send_byte(jsu_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 8)) send_token();
    if (broken) send_flaw();
    else send_byte(jsu_pkg::CH_QUOTE);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bytes outside a string: zero and the top value each give one error
  task automatic test_idle_bytes;
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // Lowest and highest pass-through bytes, one escape, close
  task automatic test_plain_bytes;
    send_byte(jsu_pkg::CH_QUOTE);
    send_byte(jsu_pkg::CH_SPACE);
    send_byte(8'hFF);
    send_byte(jsu_pkg::CH_BSLASH);
    send_byte(ESC_N);
    send_byte(jsu_pkg::CH_QUOTE);
  endtask

  // Top of the BMP (3 bytes) and the highest pair, U+10FFFF (4 bytes)
  task automatic test_unicode_extremes;
    send_byte(jsu_pkg::CH_QUOTE);
    send_unicode_escape(16'hFFFF);
    send_unicode_escape(HI_SURR_LAST);
    send_unicode_escape(LO_SURR_LAST);
    send_byte(jsu_pkg::CH_QUOTE);
  endtask

  // Control byte inside a string
  task automatic test_control_byte;
    send_byte(jsu_pkg::CH_QUOTE);
    send_byte(8'h1F);
  endtask

  // Result side held off while bytes keep coming: the command queue fills,
  // full rises and the sender has to wait
  task automatic test_result_backlog;
    idle_on = 1'b0;
    wait_for_results();
    hold_request = BACKLOG_HOLD;
    send_byte(jsu_pkg::CH_QUOTE);
    repeat (12) send_plain();
    repeat (4) send_surrogate_pair();
    send_byte(jsu_pkg::CH_QUOTE);
    wait_for_results();
    idle_on = 1'b1;
  endtask

  // Mostly well-formed strings with random content, some broken, some noise
  task automatic test_random_strings;
    int unsigned start;
    int          pick;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick = int'($urandom_range(0, 9));
      if (pick == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      else send_string(pick <= 3);
      if ($urandom_range(0, 11) == 0) wait_for_results();
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_idle_bytes();
    test_plain_bytes();
    test_unicode_extremes();
    test_control_byte();
    test_result_backlog();
    test_random_strings();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("json_string_unescape_utf8_core: match");
    end else begin
      $display("json_string_unescape_utf8_core: mismatch");
    end
    $finish;
  end

endmodule
